/* design/hxp_pkg.sv */
package hxp_pkg;

  typedef enum logic [2:0] {
    KIND_ADDR   = 3'd0,
    KIND_DATA   = 3'd1,
    KIND_END_AT = 3'd2,
    KIND_END_Q  = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    MODE_WAIT = 4'b0001,
    MODE_ADDR = 4'b0010,
    MODE_DATA = 4'b0100,
    MODE_DONE = 4'b1000
  } mode_t;

  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_Q  = 8'h71;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] POS_SAT = 32'h7FFF_FFFF;
  localparam logic [31:0] POS_NONE = 32'hFFFF_FFFF;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = 2;
  localparam int FIFO_CW = 3;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [31:0] next_position;
    logic [23:0] data_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] d;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok = 1'b1;
    h.d  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.d = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.d = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.d = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic res_t blank_res(input kind_t k);
    res_t r;
    r.kind          = k;
    r.value         = 32'd0;
    r.next_position = 32'd0;
    r.data_count    = 24'd0;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

/* design/hxp_ifs.sv */
interface hxp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_stream;
  modport source (output valid, char_code, end_of_stream, input ready);
  modport sink (input valid, char_code, end_of_stream, output ready);
endinterface

interface hxp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [31:0]        value;
  logic signed [31:0] next_position;
  logic [23:0]        data_count;
  logic               last_of_run;
  modport source (output valid, kind, value, next_position, data_count, last_of_run,
                  input ready);
  modport sink (input valid, kind, value, next_position, data_count, last_of_run,
                output ready);
endinterface

interface hxp_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* design/hex_text_section_parser_core.sv */
// Section parser for a hex text flash image, fed one character per transfer.
// The input channel carries char_code and end_of_stream; the result channel
// carries kind, value, next_position, data_count and last_of_run. The
// configuration channel writes start_offset, and is always ready; write it
// only while the block is idle.
// An accepted character lands in an input register and is decoded from there
// once the four-entry result buffer can take two more results; its results
// are then written to that buffer, whose head is offered to the receiver.
// One character is accepted per cycle while the buffer has room. A character
// that causes two results (a token end together with end of stream) writes
// both at once; the input register waits whenever the buffer cannot take two
// more results, which is what sets the rate when the receiver stalls.
// A stalled receiver simply holds the buffer; nothing is lost or reordered.
// Synchronous reset returns the parser to waiting for the first at sign,
// clears the position and count, the remembered values and start_offset, and
// empties the result buffer.
module hex_text_section_parser_core #(
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 24
) (
  input logic       clk,
  input logic       rst_n,
  hxp_in_if.sink    in_if,
  hxp_out_if.source out_if,
  hxp_cfg_if.sink   cfg_if
);

  logic                  stg_vld_r, stg_vld_nxt;
  logic [7:0]            stg_char_r;
  logic                  stg_eos_r;
  logic                  stg_fire;
  logic                  room2;
  logic                  not_empty;
  logic                  pop;
  hxp_pkg::res_t         head;

  hxp_pkg::mode_t        mode_r, mode_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  tok_r, tok_nxt;
  logic                  stop_r, stop_nxt;
  logic                  seen_r, seen_nxt;
  logic [VALUE_BITS-1:0] paddr_r, paddr_nxt;
  logic [VALUE_BITS-1:0] pdata_r, pdata_nxt;
  logic [30:0]           pos_r, pos_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [30:0]           offset_r;

  logic [1:0]            push_n;
  hxp_pkg::res_t         push_a, push_b;

  assign stg_fire     = stg_vld_r && room2;
  assign in_if.ready  = !stg_vld_r || stg_fire;
  assign stg_vld_nxt  = (stg_vld_r && !stg_fire) || in_if.valid;
  assign cfg_if.ready = 1'b1;
  assign pop          = not_empty && out_if.ready;

  always_comb begin
    hxp_pkg::hex_t           hx;
    logic [VALUE_BITS-1:0]   shifted;
    logic [VALUE_BITS-1:0]   tval;
    logic [VALUE_BITS+31:0]  vext;
    logic [COUNT_BITS+23:0]  cext;
    logic [31:0]             psum;
    hxp_pkg::res_t           main_res;
    hxp_pkg::res_t           err_res;
    logic                    main_vld;
    logic                    err_vld;

    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    tok_nxt   = tok_r;
    stop_nxt  = stop_r;
    seen_nxt  = seen_r;
    paddr_nxt = paddr_r;
    pdata_nxt = pdata_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;

    hx       = hxp_pkg::hex_digit(stg_char_r);
    shifted  = {acc_r[VALUE_BITS-5:0], hx.d};
    tval     = '0;
    vext     = '0;
    cext     = {24'd0, cnt_r};
    psum     = {1'b0, offset_r} + {1'b0, pos_r};
    main_res = hxp_pkg::blank_res(hxp_pkg::KIND_ADDR);
    err_res  = hxp_pkg::blank_res(hxp_pkg::KIND_ERROR);
    main_vld = 1'b0;
    err_vld  = 1'b0;

    if (stg_fire) begin
      case (mode_r)
        hxp_pkg::MODE_WAIT: begin
          if (stg_char_r == hxp_pkg::CH_AT) begin
            mode_nxt = hxp_pkg::MODE_ADDR;
            acc_nxt  = '0;
            tok_nxt  = 1'b0;
            stop_nxt = 1'b0;
            seen_nxt = 1'b0;
          end
        end
        hxp_pkg::MODE_ADDR: begin
          if (!hxp_pkg::is_space(stg_char_r)) begin
            tok_nxt = 1'b1;
            if (!stop_r) begin
              if (hx.ok) begin
                acc_nxt  = shifted;
                seen_nxt = 1'b1;
              end else begin
                stop_nxt = 1'b1;
              end
            end
          end else begin
            tval      = seen_r ? acc_r : paddr_r;
            paddr_nxt = tval;
            vext      = {32'd0, tval};
            main_res  = hxp_pkg::blank_res(hxp_pkg::KIND_ADDR);
            main_res.value = vext[31:0];
            main_vld  = 1'b1;
            acc_nxt   = '0;
            tok_nxt   = 1'b0;
            stop_nxt  = 1'b0;
            seen_nxt  = 1'b0;
            mode_nxt  = hxp_pkg::MODE_DATA;
          end
        end
        hxp_pkg::MODE_DATA: begin
          if (stg_char_r == hxp_pkg::CH_AT || stg_char_r == hxp_pkg::CH_Q) begin
            if (stg_char_r == hxp_pkg::CH_Q) begin
              main_res = hxp_pkg::blank_res(hxp_pkg::KIND_END_Q);
              main_res.next_position = hxp_pkg::POS_NONE;
            end else begin
              main_res = hxp_pkg::blank_res(hxp_pkg::KIND_END_AT);
              main_res.next_position = psum[31] ? hxp_pkg::POS_SAT : psum;
            end
            main_res.data_count = cext[23:0];
            main_vld = 1'b1;
            acc_nxt  = '0;
            tok_nxt  = 1'b0;
            stop_nxt = 1'b0;
            seen_nxt = 1'b0;
            mode_nxt = hxp_pkg::MODE_DONE;
          end else if (!hxp_pkg::is_space(stg_char_r)) begin
            tok_nxt = 1'b1;
            if (!stop_r) begin
              if (hx.ok) begin
                acc_nxt  = shifted;
                seen_nxt = 1'b1;
              end else begin
                stop_nxt = 1'b1;
              end
            end
          end else if (tok_r) begin
            tval      = seen_r ? acc_r : pdata_r;
            pdata_nxt = tval;
            vext      = {32'd0, tval};
            main_res  = hxp_pkg::blank_res(hxp_pkg::KIND_DATA);
            main_res.value = vext[31:0];
            main_vld  = 1'b1;
            if (cnt_r != '1) begin
              cnt_nxt = cnt_r + COUNT_BITS'(1);
            end
            acc_nxt  = '0;
            tok_nxt  = 1'b0;
            stop_nxt = 1'b0;
            seen_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase

      if (mode_r != hxp_pkg::MODE_DONE) begin
        if (pos_r != hxp_pkg::POS_MAX) begin
          pos_nxt = pos_r + 31'd1;
        end
        if (stg_eos_r && mode_nxt != hxp_pkg::MODE_DONE) begin
          err_vld  = 1'b1;
          acc_nxt  = '0;
          tok_nxt  = 1'b0;
          stop_nxt = 1'b0;
          seen_nxt = 1'b0;
          mode_nxt = hxp_pkg::MODE_DONE;
        end
      end
    end

    err_res.last = 1'b1;
    push_a = main_res;
    push_b = err_res;
    push_n = 2'd0;
    if (main_vld && err_vld) begin
      push_a.last = 1'b0;
      push_n      = 2'd2;
    end else if (main_vld) begin
      push_a.last = 1'b1;
      push_n      = 2'd1;
    end else if (err_vld) begin
      push_a = err_res;
      push_n = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      mode_r    <= hxp_pkg::MODE_WAIT;
      acc_r     <= '0;
      tok_r     <= 1'b0;
      stop_r    <= 1'b0;
      seen_r    <= 1'b0;
      paddr_r   <= '0;
      pdata_r   <= '0;
      pos_r     <= '0;
      cnt_r     <= '0;
      offset_r  <= '0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      mode_r    <= mode_nxt;
      acc_r     <= acc_nxt;
      tok_r     <= tok_nxt;
      stop_r    <= stop_nxt;
      seen_r    <= seen_nxt;
      paddr_r   <= paddr_nxt;
      pdata_r   <= pdata_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_if.valid) begin
        offset_r <= cfg_if.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      stg_char_r <= in_if.char_code;
      stg_eos_r  <= in_if.end_of_stream;
    end
  end

  hxp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_a    (push_a),
    .push_b    (push_b),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  assign out_if.valid         = not_empty;
  assign out_if.kind          = head.kind;
  assign out_if.value         = head.value;
  assign out_if.next_position = head.next_position;
  assign out_if.data_count    = head.data_count;
  assign out_if.last_of_run   = head.last;

endmodule

/* design/hxp_out_fifo.sv */
module hxp_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_n,
  input  hxp_pkg::res_t       push_a,
  input  hxp_pkg::res_t       push_b,
  input  logic                pop,
  output hxp_pkg::res_t       head,
  output logic                not_empty,
  output logic                room2
);

  hxp_pkg::res_t                    mem [hxp_pkg::FIFO_DEPTH];
  logic [hxp_pkg::FIFO_AW-1:0]      head_r, head_nxt;
  logic [hxp_pkg::FIFO_AW-1:0]      tail_r, tail_nxt;
  logic [hxp_pkg::FIFO_CW-1:0]      cnt_r, cnt_nxt;
  logic [hxp_pkg::FIFO_CW-1:0]      cnt_after_pop;
  logic [hxp_pkg::FIFO_AW-1:0]      tail_p1;

  assign not_empty     = (cnt_r != '0);
  assign head          = mem[head_r];
  assign cnt_after_pop = cnt_r - hxp_pkg::FIFO_CW'(pop);
  assign room2         = (cnt_after_pop <= hxp_pkg::FIFO_CW'(hxp_pkg::FIFO_DEPTH - 2));
  assign tail_p1       = tail_r + hxp_pkg::FIFO_AW'(1);

  always_comb begin
    head_nxt = head_r + hxp_pkg::FIFO_AW'(pop);
    tail_nxt = tail_r + hxp_pkg::FIFO_AW'(push_n);
    cnt_nxt  = cnt_after_pop + hxp_pkg::FIFO_CW'(push_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[tail_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem[tail_p1] <= push_b;
    end
  end

endmodule

/* design/hxp_checker.sv */
module hxp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [31:0] out_value,
  input logic [31:0] out_next_position,
  input logic [23:0] out_data_count,
  input logic        out_last
);

  logic term;
  assign term = (out_kind == hxp_pkg::KIND_END_AT) || (out_kind == hxp_pkg::KIND_END_Q) ||
                (out_kind == hxp_pkg::KIND_ERROR);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value) &&
      $stable(out_next_position) && $stable(out_data_count) && $stable(out_last))
    else $error("Stalled result changed.");

  a_value_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind == hxp_pkg::KIND_ADDR) || (out_kind == hxp_pkg::KIND_DATA))
      |-> out_next_position == 32'd0 && out_data_count == 24'd0)
    else $error("Address or data result carries section fields.");

  a_term_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && term |-> out_value == 32'd0 && out_last)
    else $error("Section end or error result is malformed.");

  a_q_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == hxp_pkg::KIND_END_Q) |-> out_next_position == 32'hFFFF_FFFF)
    else $error("End at q must report no next section.");

  a_nothing_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && term |=> !out_valid)
    else $error("Result delivered after the section ended.");

endmodule

bind hex_text_section_parser_core hxp_checker u_hxp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_kind          (out_if.kind),
  .out_value         (out_if.value),
  .out_next_position (out_if.next_position),
  .out_data_count    (out_if.data_count),
  .out_last          (out_if.last_of_run)
);

/* test/hex_section_checker.sv */
module hex_section_checker (
  input  logic clk,
  input  logic rst_n,
  hxp_in_if    in_ch,
  hxp_out_if   out_ch,
  hxp_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [30:0]           offset;
  hxp_pkg::mode_t        mode;
  logic [31:0]           acc;
  logic                  tok_open;
  logic                  stopped;
  logic                  seen;
  logic [31:0]           last_addr;
  logic [31:0]           last_data;
  logic [30:0]           char_pos;
  logic [23:0]           data_total;
  hxp_pkg::res_t         awaited[$];

  function automatic logic is_blank(input logic [7:0] c);
    return (c == hxp_pkg::CH_SP) || (c == hxp_pkg::CH_CR) || (c == hxp_pkg::CH_LF);
  endfunction

  function automatic hxp_pkg::res_t make_res(input hxp_pkg::kind_t k, input logic [31:0] v,
                                             input logic [31:0] pos,
                                             input logic [23:0] cnt);
    hxp_pkg::res_t r;
    r.kind          = k;
    r.value         = v;
    r.next_position = pos;
    r.data_count    = cnt;
    r.last          = 1'b0;
    return r;
  endfunction

  task automatic clear_token();
    acc      = 32'd0;
    tok_open = 1'b0;
    stopped  = 1'b0;
    seen     = 1'b0;
  endtask

  // Once a non-hex character shows up, the rest of the token only keeps it open.
  task automatic take_char(input logic [7:0] c);
    logic [3:0] d;
    logic       ok;
    tok_open = 1'b1;
    ok       = 1'b1;
    d        = 4'd0;
    if (c >= "0" && c <= "9") begin
      d = c[3:0];
    end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      d = c[3:0] + 4'd9;
    end else begin
      ok = 1'b0;
    end
    if (!stopped) begin
      if (ok) begin
        acc  = {acc[27:0], d};
        seen = 1'b1;
      end else begin
        stopped = 1'b1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got, inout bit bad);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    hxp_pkg::res_t found[2];
    int            n;
    logic [31:0]   pos;
    hxp_pkg::res_t want;
    bit            bad;
    if (!rst_n) begin
      offset     = 31'd0;
      mode       = hxp_pkg::MODE_WAIT;
      clear_token();
      last_addr  = 32'd0;
      last_data  = 32'd0;
      char_pos   = 31'd0;
      data_total = 24'd0;
      awaited.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) offset = cfg_ch.data;

      if (in_ch.valid && in_ch.ready && mode != hxp_pkg::MODE_DONE) begin
        n = 0;
        case (mode)
          hxp_pkg::MODE_WAIT: begin
            if (in_ch.char_code == hxp_pkg::CH_AT) begin
              mode = hxp_pkg::MODE_ADDR;
              clear_token();
            end
          end
          hxp_pkg::MODE_ADDR: begin
            if (!is_blank(in_ch.char_code)) begin
              take_char(in_ch.char_code);
            end else begin
              if (seen) last_addr = acc;
              found[n] = make_res(hxp_pkg::KIND_ADDR, last_addr, 32'd0, 24'd0);
              n++;
              clear_token();
              mode = hxp_pkg::MODE_DATA;
            end
          end
          default: begin
            if (in_ch.char_code == hxp_pkg::CH_Q) begin
              found[n] = make_res(hxp_pkg::KIND_END_Q, 32'd0, hxp_pkg::POS_NONE, data_total);
              n++;
              clear_token();
              mode = hxp_pkg::MODE_DONE;
            end else if (in_ch.char_code == hxp_pkg::CH_AT) begin
              pos = {1'b0, offset} + {1'b0, char_pos};
              if (pos > hxp_pkg::POS_SAT) pos = hxp_pkg::POS_SAT;
              found[n] = make_res(hxp_pkg::KIND_END_AT, 32'd0, pos, data_total);
              n++;
              clear_token();
              mode = hxp_pkg::MODE_DONE;
            end else if (!is_blank(in_ch.char_code)) begin
              take_char(in_ch.char_code);
            end else if (tok_open) begin
              if (seen) last_data = acc;
              found[n] = make_res(hxp_pkg::KIND_DATA, last_data, 32'd0, 24'd0);
              n++;
              if (data_total != '1) data_total++;
              clear_token();
            end
          end
        endcase
        if (char_pos != hxp_pkg::POS_MAX) char_pos++;
        if (in_ch.end_of_stream && mode != hxp_pkg::MODE_DONE) begin
          found[n] = make_res(hxp_pkg::KIND_ERROR, 32'd0, 32'd0, 24'd0);
          n++;
          clear_token();
          mode = hxp_pkg::MODE_DONE;
        end
        if (n > 0) found[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) awaited = {awaited, found[i]};
      end

      if (out_ch.valid && out_ch.ready) begin
        if (awaited.size() == 0) begin
          $display("%0t: result with none expected, kind %0d value %h", $time,
                   out_ch.kind, out_ch.value);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          bad  = 1'b0;
          check_field("kind", 32'(want.kind), 32'(out_ch.kind), bad);
          check_field("value", want.value, out_ch.value, bad);
          check_field("next_position", want.next_position, 32'(out_ch.next_position), bad);
          check_field("data_count", 32'(want.data_count), 32'(out_ch.data_count), bad);
          check_field("last_of_run", 32'(want.last), 32'(out_ch.last_of_run), bad);
          if (bad) fail_count++;
        end
      end
    end
    pending = awaited.size();
  end

endmodule

/* test/hex_text_section_parser_core_tb.sv */
module hex_text_section_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BODY_CHARS    = 1850;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;

  typedef enum int {
    TOK_HEX,
    TOK_LONG,
    TOK_JUNK_LEAD,
    TOK_JUNK_MID,
    TOK_PREFIX_0X
  } token_form_t;

  typedef enum int {
    END_AT,
    END_Q,
    END_EOS_BLANK,
    END_EOS_TOKEN,
    END_AT_EOS
  } ending_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   sent_chars;
  int   in_burst;
  int   out_burst;
  int   idle_cycles;

  hxp_in_if  in_ch();
  hxp_out_if out_ch();
  hxp_cfg_if cfg_ch();

  hex_text_section_parser_core DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  hex_section_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) burst = $urandom_range(10, 40);
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [7:0] hex_char();
    string digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 2))
      0: return hxp_pkg::CH_SP;
      1: return hxp_pkg::CH_CR;
      default: return hxp_pkg::CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f") ||
               c == hxp_pkg::CH_SP || c == hxp_pkg::CH_CR || c == hxp_pkg::CH_LF ||
               c == hxp_pkg::CH_AT || c == hxp_pkg::CH_Q);
    return c;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eos);
    int gap;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.char_code     <= c;
    in_ch.end_of_stream <= eos;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent_chars++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic send_hex(input int count);
    repeat (count) send_char(hex_char(), 1'b0);
  endtask

  task automatic send_token(input token_form_t form);
    case (form)
      TOK_HEX: send_hex($urandom_range(1, 8));
      TOK_LONG: send_hex($urandom_range(9, 16));
      TOK_JUNK_LEAD: begin
        repeat ($urandom_range(1, 2)) send_char(noise_char(), 1'b0);
        send_hex($urandom_range(0, 4));
      end
      TOK_JUNK_MID: begin
        send_hex($urandom_range(1, 4));
        send_char(noise_char(), 1'b0);
        send_hex($urandom_range(1, 3));
      end
      default: begin
        send_text("0x");
        send_hex($urandom_range(1, 6));
      end
    endcase
  endtask

  task automatic write_offset(input logic [30:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // A blank with no open token yields nothing, so the block may still be busy.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = draw_wait(out_burst);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("hex_text_section_parser_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int          pick;
    bit          max_written;
    bit          final_written;
    token_form_t form;
    ending_t     ending;
    logic [30:0] final_offset;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.char_code     = 8'd0;
    in_ch.end_of_stream = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = 31'd0;
    max_written         = 1'b0;
    final_written       = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    write_offset(31'($urandom));

    // Characters before the first at sign are ignored, hex digits and q included.
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("q 7");
    send_char(hxp_pkg::CH_AT, 1'b0);
    case ($urandom_range(0, 3))
      1: send_text("q@1");
      2: send_text("123456789");
      3: begin
        send_hex($urandom_range(1, 8));
        send_text("x5");
      end
      default: ;
    endcase
    send_char(blank_char(), 1'b0);
    send_text("FFFFFFFF G\r0x1F \n");

    settle();
    write_offset(31'd0);

    while (sent_chars < BODY_CHARS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) form = TOK_HEX;
      else if (pick < 85) form = TOK_LONG;
      else if (pick < 90) form = TOK_JUNK_LEAD;
      else if (pick < 95) form = TOK_JUNK_MID;
      else form = TOK_PREFIX_0X;
      send_token(form);
      repeat ($urandom_range(1, 3)) send_char(blank_char(), 1'b0);
      if (!max_written && sent_chars >= BODY_CHARS / 3) begin
        settle();
        write_offset(hxp_pkg::POS_MAX);
        max_written = 1'b1;
      end
      if (!final_written && sent_chars >= 2 * BODY_CHARS / 3) begin
        case ($urandom_range(0, 3))
          0: final_offset = 31'd0;
          1: final_offset = hxp_pkg::POS_MAX;
          2: final_offset = 31'($urandom);
          default: final_offset = hxp_pkg::POS_MAX - 31'($urandom_range(0, 3000));
        endcase
        settle();
        write_offset(final_offset);
        final_written = 1'b1;
      end
    end

    ending = ending_t'($urandom_range(0, 4));
    if (ending == END_AT || ending == END_Q) send_hex($urandom_range(0, 2));
    case (ending)
      END_AT: send_char(hxp_pkg::CH_AT, 1'b0);
      END_Q: send_char(hxp_pkg::CH_Q, 1'b0);
      END_EOS_BLANK: begin
        send_hex($urandom_range(1, 8));
        send_char(blank_char(), 1'b1);
      end
      END_EOS_TOKEN: begin
        send_hex($urandom_range(0, 7));
        send_char(hex_char(), 1'b1);
      end
      default: send_char(hxp_pkg::CH_AT, 1'b1);
    endcase

    // After the section has ended, nothing may produce a result.
    repeat (15) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_char(hxp_pkg::CH_Q, 1'b1);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("hex_text_section_parser_core_tb OK");
    end else begin
      $display("hex_text_section_parser_core_tb NOT OK");
    end
    $finish;
  end

endmodule
